FILE: rtl/gpm_pkg.sv
// Shared constants and types for the glob pattern matcher.
package gpm_pkg;

    localparam int MAX_PATTERN_LENGTH = 32;
    localparam int POS_COUNT          = MAX_PATTERN_LENGTH + 1;
    localparam int LEN_W              = 6;
    localparam int CHAR_W             = 8;
    localparam int CFG_DATA_W         = 64;
    localparam int CFG_INDEX_W        = 3;
    localparam int CHARS_PER_REG      = CFG_DATA_W / CHAR_W;
    localparam int OUT_DATA_W         = 8;

    localparam logic [CHAR_W-1:0] STAR_CHAR      = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_CHAR       = 8'h3F;
    localparam logic [CHAR_W-1:0] SLASH_CHAR     = 8'h2F;
    localparam logic [CHAR_W-1:0] BACKSLASH_CHAR = 8'h5C;

    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_A = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_B = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_C = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_D = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH  = 3'd4;

    // Broadcast from the top level to every position cell.
    typedef struct packed {
        logic              adv;    // take the next-state bit this cycle
        logic              clear;  // return to the home value
        logic              sep;    // current name byte is a separator
        logic [CHAR_W-1:0] c;      // current name byte
    } cell_ctrl_t;

endpackage

FILE: rtl/gpm_cell.sv
// One pattern position: active bit, star pass-through and byte match.
module gpm_cell import gpm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl,
    input  logic              home,
    input  logic [CHAR_W-1:0] pat_char,
    input  logic              en,
    input  logic              closure_in,
    input  logic              step_in,
    output logic              closure_out,
    output logic              step_out,
    output logic              closed
);

    logic act_reg;
    logic act_next;
    logic is_star;
    logic is_any;
    logic hit;

    assign is_star = (pat_char == STAR_CHAR);
    assign is_any  = (pat_char == ANY_CHAR);

    // star closure ripples through the chain like a carry
    assign closed      = act_reg | closure_in;
    assign closure_out = en & closed & is_star;

    assign hit      = (is_any & ~ctrl.sep) | (~is_star & ~is_any & (ctrl.c == pat_char));
    assign step_out = en & closed & hit;

    assign act_next = step_in | (en & closed & is_star & ~ctrl.sep);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= home;
        end else if (ctrl.clear) begin
            act_reg <= home;
        end else if (ctrl.adv) begin
            act_reg <= act_next;
        end
    end

endmodule

FILE: rtl/glob_pattern_matcher_unit.sv
// Top level of the glob pattern matcher: config registers, cell chain, result port.
//
// Matches a stream of name bytes against a glob pattern of up to 32 bytes held
// in the configuration registers. '*' matches any run of non-separator bytes
// (also none), '?' one non-separator byte, anything else itself; '/' and '\'
// re-enter the start of the pattern. A row of 32 identical position cells plus
// an end-of-pattern bit holds the active set; the cells hand match and star
// carries to their neighbor, so back-to-back bytes that are not the last of a
// name stream at one per cycle unless a result beat waits. The last beat of a
// name (tlast) first folds in its byte; then, with the input parked, the star
// closure of the settled set is read at the pattern length and loaded into the
// output register while the set returns to position zero. One result beat
// (matched in m_tdata bit 0) comes out per name, via pending_reg and then
// m_valid_reg; while a result beat waits unaccepted the input is held off.
module glob_pattern_matcher_unit import gpm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [CHAR_W-1:0]      s_tdata,    // [7:0] character
    input  logic                   s_tuser,    // [0] has_character
    input  logic                   s_tlast,    // last_of_name
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,    // [0] matched, [7:1] zero
    // configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [MAX_PATTERN_LENGTH-1:0][CHAR_W-1:0] pattern_reg;
    logic [LEN_W-1:0]                          length_reg;
    logic [LEN_W-1:0]                          len_eff;

    logic                 pending_reg;
    logic                 m_valid_reg;
    logic                 matched_reg;
    logic                 end_act_reg;
    logic                 end_act_next;

    logic                 s_accept;
    cell_ctrl_t           ctrl;
    logic [MAX_PATTERN_LENGTH-1:0] en;
    logic [MAX_PATTERN_LENGTH:0]   closure_carry;
    logic [MAX_PATTERN_LENGTH:0]   step_carry;
    logic [POS_COUNT-1:0]          closed;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CHARS_A: pattern_reg[0*CHARS_PER_REG +: CHARS_PER_REG] <= cfg_wdata;
                REG_CHARS_B: pattern_reg[1*CHARS_PER_REG +: CHARS_PER_REG] <= cfg_wdata;
                REG_CHARS_C: pattern_reg[2*CHARS_PER_REG +: CHARS_PER_REG] <= cfg_wdata;
                REG_CHARS_D: pattern_reg[3*CHARS_PER_REG +: CHARS_PER_REG] <= cfg_wdata;
                REG_LENGTH:  length_reg <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // lengths above the cell count saturate
    assign len_eff = (length_reg > LEN_W'(MAX_PATTERN_LENGTH)) ?
                     LEN_W'(MAX_PATTERN_LENGTH) : length_reg;

    // ---------------- handshake ----------------
    // a last beat parks the input while its result is formed in pending_reg
    assign s_tready = ~pending_reg & (~m_valid_reg | m_tready);
    assign s_accept = s_tvalid & s_tready;

    assign ctrl.adv   = s_accept & s_tuser;
    assign ctrl.clear = pending_reg;
    assign ctrl.sep   = (s_tdata == SLASH_CHAR) | (s_tdata == BACKSLASH_CHAR);
    assign ctrl.c     = s_tdata;

    // ---------------- position cells ----------------
    assign closure_carry[0] = 1'b0;
    assign step_carry[0]    = ctrl.sep;   // separator re-enters position zero

    for (genvar p = 0; p < MAX_PATTERN_LENGTH; p++) begin : g_cell
        assign en[p] = (LEN_W'(p) < len_eff);

        gpm_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .home        ((p == 0) ? 1'b1 : 1'b0),
            .pat_char    (pattern_reg[p]),
            .en          (en[p]),
            .closure_in  (closure_carry[p]),
            .step_in     (step_carry[p]),
            .closure_out (closure_carry[p+1]),
            .step_out    (step_carry[p+1]),
            .closed      (closed[p])
        );
    end

    // end-of-pattern position: no byte of its own, only collects carries
    assign closed[MAX_PATTERN_LENGTH] = end_act_reg | closure_carry[MAX_PATTERN_LENGTH];
    assign end_act_next               = step_carry[MAX_PATTERN_LENGTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_act_reg <= 1'b0;
        end else if (ctrl.clear) begin
            end_act_reg <= 1'b0;
        end else if (ctrl.adv) begin
            end_act_reg <= end_act_next;
        end
    end

    // ---------------- result ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pending_reg <= s_accept & s_tlast;
            if (pending_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pending_reg) begin
            matched_reg <= closed[len_eff];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-1){1'b0}}, matched_reg};

endmodule

FILE: rtl/gpm_checker.sv
// Port-level checks for the glob pattern matcher, bound to the top level.
module gpm_checker import gpm_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a last beat parks the input in the cycle after it is taken
    a_park: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during result cycle");

    // every last beat of a name is followed by a result beat
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |-> ##2 m_tvalid)
        else $error("missing result beat");

    // no result without a last beat
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result beat without a last input beat");

endmodule

bind glob_pattern_matcher_unit gpm_checker u_gpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
